// ===== hdl/nvr_pkg.sv =====
// Package for the normal vector renormalizer: item record and constants.
// Used by every module of the block; depends on nothing.
package nvr_pkg;

    localparam int unsigned NumChan  = 3;
    localparam int unsigned ChanW    = 8;
    localparam int unsigned CompW    = ChanW + 1;
    localparam int unsigned SqW      = 16;
    localparam int unsigned SumW     = 16;
    localparam int unsigned RhsW     = 30;
    localparam int unsigned LhsW     = 32;
    localparam logic [ChanW-1:0] Center     = 8'd127;
    localparam logic [ChanW-1:0] TwiceScale = 8'd254;

    // One pixel on its way down the pipeline
    typedef struct packed {
        logic [NumChan-1:0][ChanW-1:0] c;    // raw input bytes
        logic [NumChan-1:0][CompW-1:0] a;    // biased component, two's complement
        logic [NumChan-1:0][SqW-1:0]   sq;   // square of |2*cand-255| for the candidate under test
        logic [NumChan-1:0]            tpos; // candidate offset is positive
        logic [NumChan-1:0][RhsW-1:0]  r;    // (254*|a|)^2
        logic [NumChan-1:0][ChanW-1:0] n;    // code found so far
        logic [NumChan-1:0][ChanW-1:0] cand; // candidate under test
        logic [SumW-1:0]               s;    // squared length
        logic                          zero; // zero vector
    } t_item;

endpackage

// ===== hdl/nvr_prep.sv =====
// Front end: bias the bytes, square the components, form S and (254*|a|)^2.
// Two register stages; depends on nvr_pkg.
module nvr_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    output logic                 o_vld,
    output nvr_pkg::t_item       o_item
);

    logic                                              r_vld1;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::ChanW-1:0]   r_c1;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::CompW-1:0]   r_a1;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::SqW-1:0]     r_asq1;
    logic [nvr_pkg::NumChan-1:0][14:0]                 r_m1;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::ChanW-1:0]   n_c;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::CompW-1:0]   n_a;
    logic [nvr_pkg::NumChan-1:0][nvr_pkg::SqW-1:0]     n_asq;
    logic [nvr_pkg::NumChan-1:0][14:0]                 n_m;
    logic                                              r_vld2;
    nvr_pkg::t_item                                    r_item2;
    nvr_pkg::t_item                                    n_item2;
    logic [nvr_pkg::SumW:0]                            sum;

    // Stage one: bias, magnitude, square and scaled magnitude
    always_comb begin
        logic [nvr_pkg::CompW-1:0] neg;
        logic [nvr_pkg::ChanW-1:0] am;
        n_c = {i_blue, i_green, i_red};
        for (int i = 0; i < nvr_pkg::NumChan; i++) begin
            n_a[i]   = {1'b0, n_c[i]} - {1'b0, nvr_pkg::Center};
            neg      = '0 - n_a[i];
            am       = n_a[i][nvr_pkg::CompW-1] ? neg[nvr_pkg::ChanW-1:0]
                                                : n_a[i][nvr_pkg::ChanW-1:0];
            n_asq[i] = am * am;
            n_m[i]   = 15'(nvr_pkg::TwiceScale * am);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1   <= n_c;
            r_a1   <= n_a;
            r_asq1 <= n_asq;
            r_m1   <= n_m;
        end
    end

    // Stage two: squared length and right-hand side of the compare
    always_comb begin
        sum = {1'b0, r_asq1[0]} + {1'b0, r_asq1[1]} + {1'b0, r_asq1[2]};
        n_item2      = '0;
        n_item2.c    = r_c1;
        n_item2.a    = r_a1;
        n_item2.s    = sum[nvr_pkg::SumW-1:0];
        n_item2.zero = (sum == '0);
        for (int i = 0; i < nvr_pkg::NumChan; i++) begin
            n_item2.r[i] = r_m1[i] * r_m1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item2 <= n_item2;
        end
    end

    assign o_vld  = r_vld2;
    assign o_item = r_item2;

endmodule

// ===== hdl/nvr_bit_stage.sv =====
// One bit of the code search for all three channels, in two register stages:
// square the candidate offset, then compare t^2*S against (254*a)^2.
// Depends on nvr_pkg.
module nvr_bit_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [2:0]     i_bit,
    input  logic           i_vld,
    input  nvr_pkg::t_item i_item,
    output logic           o_vld,
    output nvr_pkg::t_item o_item
);

    logic           r_vld1;
    nvr_pkg::t_item r_item1;
    nvr_pkg::t_item n_item1;
    logic           r_vld2;
    nvr_pkg::t_item r_item2;
    nvr_pkg::t_item n_item2;

    // Build candidate and square its offset from the center code
    always_comb begin
        logic [9:0] tt;
        logic [9:0] tneg;
        logic [7:0] tm;
        n_item1 = i_item;
        for (int i = 0; i < nvr_pkg::NumChan; i++) begin
            n_item1.cand[i]     = i_item.n[i] | (8'd1 << i_bit);
            tt                  = {1'b0, n_item1.cand[i], 1'b0} - 10'd255;
            tneg                = 10'd0 - tt;
            n_item1.tpos[i]     = !tt[9];
            tm                  = tt[9] ? tneg[7:0] : tt[7:0];
            n_item1.sq[i]       = tm * tm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= n_item1;
        end
    end

    // Keep the candidate when its decision level sits at or below the value
    always_comb begin
        logic [nvr_pkg::LhsW-1:0] lhs;
        logic                     aneg;
        logic                     keep;
        n_item2 = r_item1;
        for (int i = 0; i < nvr_pkg::NumChan; i++) begin
            lhs  = r_item1.sq[i] * r_item1.s;
            aneg = r_item1.a[i][nvr_pkg::CompW-1];
            if (r_item1.tpos[i]) begin
                keep = !aneg && (lhs <= {2'b00, r_item1.r[i]});
            end else begin
                keep = !aneg || (lhs >= {2'b00, r_item1.r[i]});
            end
            n_item2.n[i] = keep ? r_item1.cand[i] : r_item1.n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item2 <= n_item2;
        end
    end

    assign o_vld  = r_vld2;
    assign o_item = r_item2;

    // Bits below the one under test are still clear after this stage
    a_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (((r_item2.n[0] | r_item2.n[1] | r_item2.n[2])
                     & ((8'd1 << i_bit) - 8'd1)) == 8'd0))
        else $error("search set a bit below the current one");

    // Only the bit under test may change
    a_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> ((((n_item2.n[0] ^ r_item1.n[0]) | (n_item2.n[1] ^ r_item1.n[1])
                     | (n_item2.n[2] ^ r_item1.n[2])) & ~(8'd1 << i_bit)) == 8'd0))
        else $error("search changed a bit other than the current one");

    // Zero vectors never reach the compare with a nonzero length
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_item1.zero == (r_item1.s == '0)))
        else $error("zero flag disagrees with squared length");

endmodule

// ===== hdl/normal_vector_renormalize.sv =====
// Top level of the normal vector renormalizer: front end, eight search
// stages and output register. Depends on nvr_pkg, nvr_prep, nvr_bit_stage.
//
// Takes one RGB8 normal-map pixel per cycle and returns it rescaled to unit
// length, each channel rounded to the nearest code (ties up), 0..254; the
// all-127 pixel passes through unchanged. One pixel enters per clock while
// the pipeline is not held; the path runs through two front-end stages, two
// stages for each of the eight bits of the code search (square the candidate,
// then one 32-bit multiply and compare) and the output register. The whole
// pipeline holds while a result waits at the output and the sink is not ready.
module normal_vector_renormalize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // red_out [7:0], green_out [15:8], blue_out [23:16]
);

    logic                     en;
    logic [8:0]               vld;
    nvr_pkg::t_item           item [9];
    logic                     r_vld;
    logic [23:0]              r_data;
    logic [23:0]              n_data;

    // Advance everything unless a result is stuck at the output
    assign en            = !(r_vld && !m_axis_tready);
    assign s_axis_tready = en;

    nvr_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_axis_tvalid),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_vld   (vld[0]),
        .o_item  (item[0])
    );

    // Search from the top code bit down
    for (genvar g = 0; g < 8; g++) begin : g_bit
        nvr_bit_stage u_bit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (3'(7 - g)),
            .i_vld   (vld[g]),
            .i_item  (item[g]),
            .o_vld   (vld[g+1]),
            .o_item  (item[g+1])
        );
    end

    // Select pass-through for the zero vector
    assign n_data = item[8].zero ? {item[8].c[2], item[8].c[1], item[8].c[0]}
                                 : {item[8].n[2], item[8].n[1], item[8].n[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= vld[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= n_data;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_data;

    // A normalized channel never reaches the top code
    a_no_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld[8] && !item[8].zero) |-> (item[8].n[0] != 8'hFF && item[8].n[1] != 8'hFF
                                       && item[8].n[2] != 8'hFF))
        else $error("normalized code out of range");

    // The zero flag only comes with the all-center pixel
    a_zero_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld[8] && item[8].zero) |-> (item[8].c[0] == nvr_pkg::Center
            && item[8].c[1] == nvr_pkg::Center && item[8].c[2] == nvr_pkg::Center))
        else $error("zero vector with off-center bytes");

    // A stalled output keeps the pipeline frozen
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !m_axis_tready && vld[8]) |=> vld[8])
        else $error("pipeline moved during output stall");

endmodule

// ===== verif/testbench.sv =====
// Testbench for normal_vector_renormalize: streams RGB8 normal-map pixels in,
// predicts each renormalized pixel with exact integer math and checks the output.
// Depends on the block's RTL only.
`timescale 1ns / 1ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red_in [7:0], green_in [15:8], blue_in [23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // red_out [7:0], green_out [15:8], blue_out [23:16]

    localparam int WatchdogLimit = 20000;

    logic [23:0] pixel_queue[$];
    logic [23:0] expected_pixels[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          error_count;
    int          quiet_cycles;

    normal_vector_renormalize DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Check whether t*sqrt(s) <= 254*a, t odd, s > 0
    function automatic bit at_or_below(int t, int a, longint s);
        longint tm;
        longint am;
        if (t <= 0 && a >= 0) return 1'b1;
        if (t > 0 && a < 0) return 1'b0;
        tm = (t < 0) ? -t : t;
        am = (a < 0) ? -a : a;
        if (t > 0) return tm * tm * s <= 64516 * am * am;
        return tm * tm * s >= 64516 * am * am;
    endfunction

    // Largest code n with (2n-255) <= 254*a/sqrt(s)
    function automatic logic [7:0] round_channel(int a, longint s);
        for (int n = 254; n > 0; n--)
            if (at_or_below(2 * n - 255, a, s)) return n[7:0];
        return 8'd0;
    endfunction

    function automatic logic [23:0] renormalize_pixel(logic [23:0] px);
        int          comp[3];
        longint      len_sq;
        logic [23:0] res;
        len_sq = 0;
        for (int i = 0; i < 3; i++) begin
            comp[i] = int'(px[8*i +: 8]) - 127;
            len_sq += comp[i] * comp[i];
        end
        if (len_sq == 0) return px;
        for (int i = 0; i < 3; i++) res[8*i +: 8] = round_channel(comp[i], len_sq);
        return res;
    endfunction

    // Append a pending request
    function automatic void queue_pixel(logic [23:0] px);
        pixel_queue = {pixel_queue, px};
    endfunction

    // Append a prediction for an accepted request
    function automatic void queue_expected(logic [23:0] px);
        expected_pixels = {expected_pixels, px};
    endfunction

    // Drive requests: advance on acceptance, idle at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) queue_expected(renormalize_pixel(s_axis_tdata));
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink: stall at random or hold off for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                for (int i = 0; i < 3; i++)
                    if (want[8*i +: 8] !== m_axis_tdata[8*i +: 8]) begin
                        $display("%0t: channel %0d mismatch, expected %h, actual %h",
                                 $time, i, want[8*i +: 8], m_axis_tdata[8*i +: 8]);
                        error_count++;
                    end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
            @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(5))
            0:       return 8'd127 + 8'($urandom_range(2)) - 8'd1;
            1:       return $urandom_range(1) ? 8'd0 : 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int extremes[6];
        extremes = '{0, 1, 126, 127, 128, 255};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero vector, axis extremes, corners, near-zero vectors
        queue_pixel({8'd127, 8'd127, 8'd127});
        for (int i = 0; i < 3; i++) begin
            queue_pixel(24'h7f7f7f & ~(24'hff << 8*i));
            queue_pixel(24'h7f7f7f | (24'hff << 8*i));
            queue_pixel(24'h7f7f7f ^ (24'h01 << 8*i) ^ (24'h7e << 8*i) ^ (24'h7f << 8*i));
        end
        queue_pixel(24'h000000);
        queue_pixel(24'hffffff);
        queue_pixel(24'h00ff00);
        queue_pixel(24'hff00ff);
        queue_pixel(24'h807f7e);
        queue_pixel(24'h808080);
        queue_pixel(24'h7e7e7e);
        queue_pixel(24'haa5533);
        for (int k = 0; k < 6; k++)
            queue_pixel({8'($urandom_range(255)), 8'd127, 8'(extremes[k])});
        wait_drained();

        // Random phases with different idling, plus one long sink hold-off
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) hold_off_cycles = 200;
            for (int k = 0; k < 205; k++)
                queue_pixel({rand_chan(), rand_chan(), rand_chan()});
            wait_drained();
        end
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
